/* rtl/pvcd_pkg.sv */
// ----------------------------------------------------------------------------
// pvcd_pkg
// Shared types and constants for the peak and valley cycle detector.
// ----------------------------------------------------------------------------
package pvcd_pkg;

  localparam int SAMPLE_BITS_DEFAULT = 16;
  localparam int INDEX_BITS_DEFAULT  = 20;

  localparam int RATIO_BITS     = 10;
  localparam int FLOOR_BITS     = 16;
  localparam int WINDOW_BITS    = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [RATIO_BITS-1:0]  CYCLE_RATIO_RESET   = RATIO_BITS'(70);
  localparam logic [RATIO_BITS-1:0]  CONFIRM_RATIO_RESET = RATIO_BITS'(49);
  localparam logic [FLOOR_BITS-1:0]  PEAK_FLOOR_RESET    = '0;
  localparam logic [WINDOW_BITS-1:0] WINDOW_LENGTH_RESET = WINDOW_BITS'(10);

  localparam int TENTHS_SCALE = 10;
  localparam int QUEUE_DEPTH  = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_CYCLE_RATIO   = 2'd0,
    CFG_CONFIRM_RATIO = 2'd1,
    CFG_PEAK_FLOOR    = 2'd2,
    CFG_WINDOW_LENGTH = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [RATIO_BITS-1:0]  cycle_ratio_tenths;
    logic [RATIO_BITS-1:0]  confirm_ratio_tenths;
    logic [FLOOR_BITS-1:0]  peak_floor;
    logic [WINDOW_BITS-1:0] window_length;
  } cfg_regs_t;

  typedef struct packed {
    logic boundary;
    logic summary;
    logic trail;
  } rec_flags_t;

endpackage

/* rtl/pvcd_core.sv */
// ----------------------------------------------------------------------------
// pvcd_core
// Stream state and combinational detection step for one registered sample.
// ----------------------------------------------------------------------------
module pvcd_core #(
  parameter int SAMPLE_BITS = pvcd_pkg::SAMPLE_BITS_DEFAULT,
  parameter int INDEX_BITS  = pvcd_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pvcd_pkg::cfg_regs_t           cfg,
  input  logic                          item_valid,
  input  logic signed [SAMPLE_BITS-1:0] item_sample,
  input  logic                          item_end,
  output logic                          rec_valid,
  output pvcd_pkg::rec_flags_t          rec_flags,
  output logic [INDEX_BITS:0]           bnd_length,
  output logic [INDEX_BITS-1:0]         bnd_total,
  output logic [INDEX_BITS:0]           sum_length,
  output logic [INDEX_BITS-1:0]         sum_total,
  output logic [INDEX_BITS-1:0]         sum_split,
  output logic [INDEX_BITS:0]           sum_test
);
  import pvcd_pkg::*;

  localparam int SW   = SAMPLE_BITS;
  localparam int IW   = INDEX_BITS;
  localparam int LW   = IW + 1;
  localparam int PW   = SW + RATIO_BITS;
  localparam int CMPW = (SW > FLOOR_BITS) ? SW : FLOOR_BITS;
  localparam logic [IW-1:0] INDEX_MAX = '1;
  localparam logic [LW-1:0] COUNT_MAX = {1'b1, {IW{1'b0}}};
  localparam logic [PW-1:0] TEN       = PW'(TENTHS_SCALE);

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] x);
    logic [SW-1:0] u;
    u = x;
    return x[SW-1] ? (~u + SW'(1)) : u;
  endfunction

  logic signed [SW-1:0] older, older_next;
  logic signed [SW-1:0] middle, middle_next;
  logic signed [SW-1:0] vval, vval_next;
  logic signed [SW-1:0] pval, pval_next;
  logic                 vv, vv_next;
  logic                 pv, pv_next;
  logic [IW-1:0]        vidx, vidx_next;
  logic [IW-1:0]        earlier, earlier_next;
  logic [IW-1:0]        current, current_next;
  logic                 seen, seen_next;
  logic [IW-1:0]        cycles, cycles_next;
  logic [LW-1:0]        pos, pos_next;

  logic                   primed;
  logic [IW-1:0]          midx;
  logic                   valley_hit, peak_hit, first_valley;
  logic signed [SW-1:0]   vval1, pval1;
  logic                   vv1, vv2, pv1, vv3, pv3;
  logic [IW-1:0]          vidx1, earlier1, current1, earlier2, current2, earlier3;
  logic signed [CMPW-1:0] middle_cmp, pval_cmp, floor_cmp;
  logic [PW-1:0]          p10, ratio_v, ratio_s, conf_o, conf_m, conf_s;
  logic                   boundary, trail;
  logic [IW-1:0]          cycles1, cycles2;
  logic [LW-1:0]          count;
  logic [IW-1:0]          lastidx;

  assign primed = (pos[LW-1:1] != '0);
  assign midx   = pos[IW-1:0] - IW'(1);

  assign middle_cmp = CMPW'(middle);
  assign pval_cmp   = CMPW'(pval1);
  assign floor_cmp  = CMPW'($signed(cfg.peak_floor));

  assign valley_hit = primed && (older >= middle) && (middle <= item_sample) &&
                      (!vv || (middle < vval));
  assign first_valley = valley_hit && !seen;
  assign vval1    = valley_hit ? middle : vval;
  assign vv1      = vv | valley_hit;
  assign vidx1    = valley_hit ? midx : vidx;
  assign earlier1 = first_valley ? midx : earlier;
  assign current1 = first_valley ? midx : current;

  assign peak_hit = primed && (older <= middle) && (middle >= item_sample) &&
                    (!pv || (middle > pval)) && (middle_cmp > floor_cmp);
  assign pval1 = peak_hit ? middle : pval;
  assign pv1   = pv | peak_hit;
  assign vv2   = vv1 & ~peak_hit;

  assign p10     = PW'(mag(pval1)) * TEN;
  assign ratio_v = PW'(cfg.cycle_ratio_tenths) * PW'(mag(vval1));
  assign ratio_s = PW'(cfg.cycle_ratio_tenths) * PW'(mag(item_sample));
  assign conf_o  = PW'(cfg.confirm_ratio_tenths) * PW'(mag(older));
  assign conf_m  = PW'(cfg.confirm_ratio_tenths) * PW'(mag(middle));
  assign conf_s  = PW'(cfg.confirm_ratio_tenths) * PW'(mag(item_sample));

  assign boundary = primed && pv1 && vv2 && (pval1 != '0) && (p10 >= ratio_v) &&
                    (p10 < conf_o) && (p10 < conf_m) && (p10 < conf_s);

  assign earlier2 = boundary ? current1 : earlier1;
  assign current2 = boundary ? vidx1 : current1;
  assign cycles1  = (boundary && (cycles != INDEX_MAX)) ? cycles + IW'(1) : cycles;
  assign vv3      = vv2 & ~boundary;
  assign pv3      = pv1 & ~boundary;

  assign bnd_length = (cycles == '0) ? LW'(vidx1) + LW'(1) : LW'(vidx1) - LW'(current1);
  assign bnd_total  = cycles1;

  assign count   = (pos != COUNT_MAX) ? pos + LW'(1) : pos;
  assign lastidx = pos[IW] ? INDEX_MAX : pos[IW-1:0];

  assign trail = item_end && pv3 && (pval_cmp > floor_cmp) && (pval1 != '0) &&
                 (p10 >= ratio_s);
  assign earlier3 = trail ? current2 : earlier2;
  assign cycles2  = (trail && (cycles1 != INDEX_MAX)) ? cycles1 + IW'(1) : cycles1;

  assign sum_length = trail ? LW'(lastidx) - LW'(current2) : '0;
  assign sum_total  = cycles2;
  assign sum_split  = earlier3;
  assign sum_test   = count - LW'(earlier3) + LW'(cfg.window_length);

  assign rec_valid          = item_valid && (boundary || item_end);
  assign rec_flags.boundary = boundary;
  assign rec_flags.summary  = item_end;
  assign rec_flags.trail    = trail;

  always_comb begin
    older_next   = primed ? middle : ((pos == '0) ? item_sample : older);
    middle_next  = (pos != '0) ? item_sample : middle;
    vval_next    = vval1;
    pval_next    = pval1;
    vv_next      = vv3;
    pv_next      = pv3;
    vidx_next    = vidx1;
    earlier_next = earlier2;
    current_next = current2;
    seen_next    = seen | valley_hit;
    cycles_next  = cycles1;
    pos_next     = count;
  end

  always_ff @(posedge clk) begin
    if (rst || (item_valid && item_end)) begin
      older   <= '0;
      middle  <= '0;
      vval    <= '0;
      pval    <= '0;
      vv      <= 1'b0;
      pv      <= 1'b0;
      vidx    <= '0;
      earlier <= '0;
      current <= '0;
      seen    <= 1'b0;
      cycles  <= '0;
      pos     <= '0;
    end else if (item_valid) begin
      older   <= older_next;
      middle  <= middle_next;
      vval    <= vval_next;
      pval    <= pval_next;
      vv      <= vv_next;
      pv      <= pv_next;
      vidx    <= vidx_next;
      earlier <= earlier_next;
      current <= current_next;
      seen    <= seen_next;
      cycles  <= cycles_next;
      pos     <= pos_next;
    end
  end

endmodule

/* rtl/peak_valley_cycle_detector.sv */
// ----------------------------------------------------------------------------
// peak_valley_cycle_detector
// Finds valley-to-valley cycles in a signed sample stream and summarises
// each stream at its final sample.
// ----------------------------------------------------------------------------
// One sample is taken every clock cycle while in_stall is low. A sample is
// held in an input register while the detection step runs, and its results
// are written to a four-entry result queue, so a result is offered once the
// staged sample's record has been written into the queue.
// A sample that both ends a cycle and ends the stream yields two results,
// delivered one after the other from one queue entry; only then can the
// output port, when not stalled, fall behind the input. New samples are held
// off while the queue, counting the staged sample, is full. Configuration
// writes are taken on any cycle outside reset.
module peak_valley_cycle_detector #(
  parameter int SAMPLE_BITS = pvcd_pkg::SAMPLE_BITS_DEFAULT,
  parameter int INDEX_BITS  = pvcd_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pvcd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pvcd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  logic                                end_of_stream,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                is_summary,
  output logic                                cycle_found,
  output logic [INDEX_BITS:0]                 cycle_length,
  output logic [INDEX_BITS-1:0]               cycle_total,
  output logic [INDEX_BITS-1:0]               split_index,
  output logic [INDEX_BITS:0]                 test_count,
  output logic                                final_result
);
  import pvcd_pkg::*;

  localparam int IW = INDEX_BITS;
  localparam int LW = IW + 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = QW + 1;

  cfg_regs_t cfg;

  logic                         stage_valid;
  logic signed [SAMPLE_BITS-1:0] stage_sample;
  logic                         stage_end;

  logic          rec_valid;
  rec_flags_t    rec_flags;
  logic [LW-1:0] bnd_length, sum_length, sum_test;
  logic [IW-1:0] bnd_total, sum_total, sum_split;

  rec_flags_t    q_flags      [QUEUE_DEPTH];
  logic [LW-1:0] q_bnd_length [QUEUE_DEPTH];
  logic [IW-1:0] q_bnd_total  [QUEUE_DEPTH];
  logic [LW-1:0] q_sum_length [QUEUE_DEPTH];
  logic [IW-1:0] q_sum_total  [QUEUE_DEPTH];
  logic [IW-1:0] q_sum_split  [QUEUE_DEPTH];
  logic [LW-1:0] q_sum_test   [QUEUE_DEPTH];

  logic [QW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] level, level_next;
  logic          head_part;
  logic          show_boundary;
  logic          take, pop;
  rec_flags_t    head_flags;

  assign cfg_ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cycle_ratio_tenths   <= CYCLE_RATIO_RESET;
      cfg.confirm_ratio_tenths <= CONFIRM_RATIO_RESET;
      cfg.peak_floor           <= PEAK_FLOOR_RESET;
      cfg.window_length        <= WINDOW_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CYCLE_RATIO:   cfg.cycle_ratio_tenths   <= cfg_data[RATIO_BITS-1:0];
        CFG_CONFIRM_RATIO: cfg.confirm_ratio_tenths <= cfg_data[RATIO_BITS-1:0];
        CFG_PEAK_FLOOR:    cfg.peak_floor           <= cfg_data[FLOOR_BITS-1:0];
        CFG_WINDOW_LENGTH: cfg.window_length        <= cfg_data[WINDOW_BITS-1:0];
      endcase
    end
  end

  // hold off new samples unless the queue has room for this one and the staged one
  assign in_stall = rst || ((level + CW'(stage_valid)) >= CW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_sample <= sample;
      stage_end    <= end_of_stream;
    end
  end

  pvcd_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (stage_valid),
    .item_sample (stage_sample),
    .item_end    (stage_end),
    .rec_valid   (rec_valid),
    .rec_flags   (rec_flags),
    .bnd_length  (bnd_length),
    .bnd_total   (bnd_total),
    .sum_length  (sum_length),
    .sum_total   (sum_total),
    .sum_split   (sum_split),
    .sum_test    (sum_test)
  );

  always_ff @(posedge clk) begin
    if (rec_valid) begin
      q_flags[wr_ptr]      <= rec_flags;
      q_bnd_length[wr_ptr] <= bnd_length;
      q_bnd_total[wr_ptr]  <= bnd_total;
      q_sum_length[wr_ptr] <= sum_length;
      q_sum_total[wr_ptr]  <= sum_total;
      q_sum_split[wr_ptr]  <= sum_split;
      q_sum_test[wr_ptr]   <= sum_test;
    end
  end

  assign head_flags    = q_flags[rd_ptr];
  assign show_boundary = head_flags.boundary && !head_part;

  assign out_valid    = !rst && (level != '0);
  assign is_summary   = !show_boundary;
  assign cycle_found  = show_boundary || head_flags.trail;
  assign cycle_length = show_boundary ? q_bnd_length[rd_ptr] : q_sum_length[rd_ptr];
  assign cycle_total  = show_boundary ? q_bnd_total[rd_ptr] : q_sum_total[rd_ptr];
  assign split_index  = show_boundary ? '0 : q_sum_split[rd_ptr];
  assign test_count   = show_boundary ? '0 : q_sum_test[rd_ptr];
  assign final_result = !show_boundary || !head_flags.summary;

  assign take       = out_valid && !out_stall;
  assign pop        = take && final_result;
  assign level_next = level + CW'(rec_valid) - CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      level     <= '0;
      head_part <= 1'b0;
    end else begin
      level <= level_next;
      if (rec_valid) begin
        wr_ptr <= wr_ptr + QW'(1);
      end
      if (pop) begin
        rd_ptr    <= rd_ptr + QW'(1);
        head_part <= 1'b0;
      end else if (take) begin
        head_part <= 1'b1;
      end
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the peak and valley cycle detector. A clocked
// driver feeds samples from a backlog with random gaps and a clocked monitor
// takes results under random stall. Each accepted sample is run through a
// local model of the detector, and every result is compared field by field
// with the oldest outstanding report. Register settings change between
// phases, while the block is idle, and include the extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import pvcd_pkg::*;

  localparam longint unsigned IDX_MAX     = (64'd1 << 20) - 64'd1;
  localparam longint unsigned COUNT_MAX   = 64'd1 << 20;
  localparam int              QUIET_LIMIT = 1000;
  localparam int              SETTLE      = 8;
  localparam int              PHASE_ITEMS = 120;
  localparam int              PHASES      = 9;

  typedef struct {
    logic signed [15:0] smp;
    logic               eos;
  } sample_item_t;

  typedef struct {
    logic        summary;
    logic        found;
    logic [20:0] len;
    logic [19:0] total;
    logic [19:0] split;
    logic [20:0] tcount;
    logic        fin;
  } cycle_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_CYCLE_RATIO;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic signed [15:0] sample        = '0;
  logic               end_of_stream = 1'b0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_summary;
  logic        cycle_found;
  logic [20:0] cycle_length;
  logic [19:0] cycle_total;
  logic [19:0] split_index;
  logic [20:0] test_count;
  logic        final_result;

  // register copies
  logic [9:0]         cfg_cycle_ratio = CYCLE_RATIO_RESET;
  logic [9:0]         cfg_confirm     = CONFIRM_RATIO_RESET;
  logic signed [15:0] cfg_floor       = PEAK_FLOOR_RESET;
  logic [15:0]        cfg_window      = WINDOW_LENGTH_RESET;

  // detector state
  logic signed [15:0] h_old, h_mid, lo_val, hi_val;
  logic               lo_held, hi_held, lo_seen;
  logic [19:0]        lo_idx, lo_prev_idx, lo_cur_idx, n_cycles;
  logic [20:0]        n_samples;

  sample_item_t  sample_backlog[$];
  cycle_report_t cycle_reports[$];
  sample_item_t  next_item;
  cycle_report_t want;

  int samples_queued = 0;
  int samples_taken  = 0;
  int phase_items    = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;
  int in_hold        = 0;
  int out_hold       = 0;
  bit in_calm        = 1'b0;
  bit out_calm       = 1'b0;

  peak_valley_cycle_detector DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample        (sample),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_summary    (is_summary),
    .cycle_found   (cycle_found),
    .cycle_length  (cycle_length),
    .cycle_total   (cycle_total),
    .split_index   (split_index),
    .test_count    (test_count),
    .final_result  (final_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned magnitude(logic signed [15:0] x);
    longint v;
    v = x;
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  task automatic clear_detector();
    h_old       = '0;
    h_mid       = '0;
    lo_val      = '0;
    hi_val      = '0;
    lo_held     = 1'b0;
    hi_held     = 1'b0;
    lo_seen     = 1'b0;
    lo_idx      = '0;
    lo_prev_idx = '0;
    lo_cur_idx  = '0;
    n_cycles    = '0;
    n_samples   = '0;
  endtask

  task automatic step_detector(logic signed [15:0] s, logic eos);
    cycle_report_t    r;
    longint unsigned  pos, midx, p10, len, tail_len, lastidx, split, count;
    bit               trail;
    pos      = n_samples;
    trail    = 1'b0;
    tail_len = 0;
    if (pos >= 2) begin
      midx = pos - 1;
      if (midx > IDX_MAX) midx = IDX_MAX;
      if (h_old >= h_mid && h_mid <= s && (!lo_held || h_mid < lo_val)) begin
        lo_val  = h_mid;
        lo_held = 1'b1;
        lo_idx  = midx[19:0];
        if (!lo_seen) begin
          lo_prev_idx = midx[19:0];
          lo_cur_idx  = midx[19:0];
          lo_seen     = 1'b1;
        end
      end
      if (h_old <= h_mid && h_mid >= s && (!hi_held || h_mid > hi_val) &&
          h_mid > cfg_floor) begin
        hi_val  = h_mid;
        hi_held = 1'b1;
        lo_held = 1'b0;
      end
      if (hi_held && lo_held && hi_val != 0) begin
        p10 = 10 * magnitude(hi_val);
        if (p10 >= cfg_cycle_ratio * magnitude(lo_val) &&
            p10 < cfg_confirm * magnitude(h_old) &&
            p10 < cfg_confirm * magnitude(h_mid) &&
            p10 < cfg_confirm * magnitude(s)) begin
          lo_prev_idx = lo_cur_idx;
          lo_cur_idx  = lo_idx;
          if (n_cycles == 0) len = lo_cur_idx + 64'd1;
          else len = lo_cur_idx - lo_prev_idx;
          if (n_cycles < IDX_MAX) n_cycles++;
          lo_held   = 1'b0;
          hi_held   = 1'b0;
          r.summary = 1'b0;
          r.found   = 1'b1;
          r.len     = len[20:0];
          r.total   = n_cycles;
          r.split   = '0;
          r.tcount  = '0;
          r.fin     = !eos;
          cycle_reports.push_back(r);
        end
      end
      h_old = h_mid;
      h_mid = s;
    end else if (pos == 1) begin
      h_mid = s;
    end else begin
      h_old = s;
    end
    if (n_samples < COUNT_MAX) n_samples++;
    if (eos) begin
      if (hi_held && hi_val > cfg_floor && hi_val != 0 &&
          10 * magnitude(hi_val) >= cfg_cycle_ratio * magnitude(s)) begin
        lastidx     = (pos > IDX_MAX) ? IDX_MAX : pos;
        trail       = 1'b1;
        lo_prev_idx = lo_cur_idx;
        tail_len    = lastidx - lo_prev_idx;
        if (n_cycles < IDX_MAX) n_cycles++;
      end
      split     = lo_prev_idx;
      count     = n_samples;
      count     = count - split + cfg_window;
      r.summary = 1'b1;
      r.found   = trail;
      r.len     = tail_len[20:0];
      r.total   = n_cycles;
      r.split   = split[19:0];
      r.tcount  = count[20:0];
      r.fin     = 1'b1;
      cycle_reports.push_back(r);
      clear_detector();
    end
  endtask

  task automatic check_field(string name, logic [20:0] exp_v, logic [20:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_hold = 0;
    end else begin
      if (in_valid && !in_stall) begin
        step_detector(sample, end_of_stream);
        samples_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (in_hold > 0) begin
          in_valid <= 1'b0;
          in_hold--;
        end else if (sample_backlog.size() > 0) begin
          next_item = sample_backlog.pop_front();
          in_valid      <= 1'b1;
          sample        <= next_item.smp;
          end_of_stream <= next_item.eos;
          if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
          in_hold = in_calm ? 0 : int'($urandom_range(0, 4));
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cycle_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual is_summary %0d",
                   $time, is_summary);
          mismatches++;
        end else begin
          want = cycle_reports.pop_front();
          check_field("is_summary", want.summary, is_summary);
          check_field("cycle_found", want.found, cycle_found);
          check_field("cycle_length", want.len, cycle_length);
          check_field("cycle_total", want.total, cycle_total);
          check_field("split_index", want.split, split_index);
          check_field("test_count", want.tcount, test_count);
          check_field("final_result", want.fin, final_result);
        end
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_hold = out_calm ? 0 : int'($urandom_range(0, 4));
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(logic signed [15:0] s, logic eos);
    sample_item_t it;
    it.smp = s;
    it.eos = eos;
    sample_backlog.push_back(it);
    samples_queued++;
    phase_items++;
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CYCLE_RATIO:   cfg_cycle_ratio = val[9:0];
      CFG_CONFIRM_RATIO: cfg_confirm     = val[9:0];
      CFG_PEAK_FLOOR:    cfg_floor       = val;
      CFG_WINDOW_LENGTH: cfg_window      = val;
      default: ;
    endcase
  endtask

  // hold until every sample is taken and every report returned
  task automatic drain();
    while (samples_taken != samples_queued || cycle_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_wave_stream();
    logic signed [15:0] wave[$];
    longint pk, vl, vmag, v;
    int     ncyc, up, dn, drop;
    ncyc = $urandom_range(1, 4);
    dn   = 1;
    vmag = 2000;
    vl   = int'($urandom_range(0, 400)) - 200;
    wave.push_back(clamp16(vl));
    for (int c = 0; c < ncyc; c++) begin
      pk = $urandom_range(300, 30000);
      if (pk <= cfg_floor) pk = longint'(cfg_floor) + 1;
      if (cfg_cycle_ratio != 0) vmag = (10 * pk) / cfg_cycle_ratio;
      else vmag = pk;
      if (vmag >= pk) vmag = pk - 1;
      if (vmag < 0) vmag = 0;
      up = $urandom_range(2, 8);
      dn = $urandom_range(2, 8);
      for (int i = 1; i <= up; i++) begin
        v = vl + (pk - vl) * i / up;
        if ($urandom_range(0, 3) == 0) v += int'($urandom_range(0, 16)) - 8;
        wave.push_back(clamp16(v));
      end
      v  = $urandom_range(0, int'(vmag));
      vl = ($urandom_range(0, 2) == 0) ? -v : v;
      for (int i = 1; i <= dn; i++) begin
        v = pk + (vl - pk) * i / dn;
        if ($urandom_range(0, 3) == 0) v += int'($urandom_range(0, 16)) - 8;
        wave.push_back(clamp16(v));
      end
    end
    drop = $urandom_range(0, dn);
    repeat (drop) void'(wave.pop_back());
    foreach (wave[i]) queue_item(wave[i], i == wave.size() - 1);
  endtask

  task automatic queue_noise_stream();
    int  len;
    bit  closes;
    len    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 24);
    closes = $urandom_range(0, 3) != 0;
    for (int i = 0; i < len; i++)
      queue_item(16'($urandom_range(0, 65535)), closes && i == len - 1);
  endtask

  initial begin : stimulus
    logic [15:0] cr, cf, fl, wl;
    clear_detector();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // single-sample and two-sample streams at the sample extremes
    queue_item(-16'sd32768, 1'b1);
    queue_item(16'sd32767, 1'b0);
    queue_item(-16'sd32768, 1'b1);
    // two rise-and-fall swings, the second closing on the final sample
    queue_item(16'sd500, 1'b0);
    queue_item(16'sd1000, 1'b0);
    queue_item(16'sd600, 1'b0);
    queue_item(16'sd100, 1'b0);
    queue_item(16'sd400, 1'b0);
    queue_item(16'sd700, 1'b0);
    queue_item(16'sd900, 1'b0);
    queue_item(16'sd1200, 1'b0);
    queue_item(16'sd800, 1'b0);
    queue_item(16'sd50, 1'b0);
    queue_item(16'sd300, 1'b0);
    queue_item(16'sd600, 1'b0);
    queue_item(16'sd900, 1'b1);
    // trailing cycle on the final sample
    queue_item(16'sd100, 1'b0);
    queue_item(16'sd2000, 1'b0);
    queue_item(16'sd500, 1'b0);
    queue_item(16'sd150, 1'b1);
    // peak below the floor
    queue_item(-16'sd100, 1'b0);
    queue_item(-16'sd50, 1'b0);
    queue_item(-16'sd80, 1'b1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin cr = 16'd1;    cf = 16'd1023; fl = 16'h8000; wl = 16'hffff; end
        1: begin cr = 16'd1023; cf = 16'd1;    fl = 16'h7fff; wl = 16'd1;    end
        2: begin cr = 16'd0;    cf = 16'd0;    fl = 16'hffff; wl = 16'h8000; end
        default: begin
          cr = 16'($urandom_range(5, 120));
          cf = 16'($urandom_range(20, 300));
          fl = 16'(int'($urandom_range(0, 6000)) - 3000);
          wl = 16'($urandom_range(1, 65535));
        end
      endcase
      write_reg(CFG_CYCLE_RATIO, cr);
      write_reg(CFG_CONFIRM_RATIO, cf);
      write_reg(CFG_PEAK_FLOOR, fl);
      write_reg(CFG_WINDOW_LENGTH, wl);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) != 0) queue_wave_stream();
        else queue_noise_stream();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
